// ===== rtl/core/mrtu_pkg.sv =====
// Shared types, constants and helper functions for the Modbus RTU receive framer.
// No dependencies; the frame controller, output buffer and top level import this package.
`timescale 1ns / 1ps

package mrtu_pkg;

	// Frame size limits
	localparam int MAX_FRAME_BYTES = 256;
	localparam int MIN_FRAME_BYTES = 4;
	localparam int BCNT_W          = $clog2(MAX_FRAME_BYTES + 1);

	// Modbus CRC-16, reflected
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Configuration reset values and register indexes
	localparam logic [7:0] DEV_ADDR_RST = 8'd10;
	localparam logic [7:0] TIMEOUT_RST  = 8'd3;
	localparam logic       CFG_DEV_ADDR = 1'b0;
	localparam logic       CFG_TIMEOUT  = 1'b1;

	// Broadcast address
	localparam logic [7:0] ADDR_BCAST = 8'h00;

	// Event counter slots
	localparam int NUM_CNT      = 8;
	localparam int CNT_SEEN     = 0;
	localparam int CNT_FOR_ME   = 1;
	localparam int CNT_SHORT    = 2;
	localparam int CNT_CRC      = 3;
	localparam int CNT_OVERFLOW = 4;
	localparam int CNT_OVERRUN  = 5;
	localparam int CNT_PARITY   = 6;
	localparam int CNT_FRAMING  = 7;

	typedef enum logic [1:0] {
		REQ_BYTE    = 2'd0,
		REQ_TICK    = 2'd1,
		REQ_TX_DONE = 2'd2
	} req_code_t;

	typedef enum logic [2:0] {
		VERDICT_SHORT    = 3'd0,
		VERDICT_CRC_ERR  = 3'd1,
		VERDICT_OTHER    = 3'd2,
		VERDICT_BCAST    = 3'd3,
		VERDICT_FOR_ME   = 3'd4
	} verdict_t;

	typedef enum logic [2:0] {
		MODE_IDLE       = 3'b001,
		MODE_RECEIVING  = 3'b010,
		MODE_RESPONDING = 3'b100
	} mode_t;

	// One input word
	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] rx_byte;
		logic       overrun_flag;
		logic       parity_flag;
		logic       framing_flag;
	} req_t;

	// One result word
	typedef struct packed {
		verdict_t    verdict;
		logic [7:0]  frame_address;
		logic [7:0]  pdu_length;
		logic [15:0] frames_seen;
		logic [15:0] frames_for_me;
		logic [15:0] short_frames;
		logic [15:0] crc_errors;
		logic [15:0] buffer_overflows;
		logic [15:0] overrun_errors;
		logic [15:0] parity_errors;
		logic [15:0] framing_errors;
	} rsp_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [15:0] sat_inc16(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

endpackage

// ===== rtl/core/mrtu_if.sv =====
// Valid/ready channel interfaces for the request and result words.
// Depends on nothing; field names follow the block's port payload.
`timescale 1ns / 1ps

interface mrtu_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] rx_byte;
	logic       overrun_flag;
	logic       parity_flag;
	logic       framing_flag;

	modport source (output valid, req_type, rx_byte, overrun_flag, parity_flag, framing_flag,
		input ready);
	modport sink (input valid, req_type, rx_byte, overrun_flag, parity_flag, framing_flag,
		output ready);
endinterface

interface mrtu_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  verdict;
	logic [7:0]  frame_address;
	logic [7:0]  pdu_length;
	logic [15:0] frames_seen;
	logic [15:0] frames_for_me;
	logic [15:0] short_frames;
	logic [15:0] crc_errors;
	logic [15:0] buffer_overflows;
	logic [15:0] overrun_errors;
	logic [15:0] parity_errors;
	logic [15:0] framing_errors;

	modport source (output valid, verdict, frame_address, pdu_length, frames_seen,
		frames_for_me, short_frames, crc_errors, buffer_overflows, overrun_errors,
		parity_errors, framing_errors, input ready);
	modport sink (input valid, verdict, frame_address, pdu_length, frames_seen,
		frames_for_me, short_frames, crc_errors, buffer_overflows, overrun_errors,
		parity_errors, framing_errors, output ready);
endinterface

// ===== rtl/core/mrtu_frame_ctrl.sv =====
// Input stage and framing state: CRC, byte count, silence timer, counters, verdict.
// Depends on mrtu_pkg; pushes one result word into the output buffer per ended frame.
`timescale 1ns / 1ps

module mrtu_frame_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mrtu_pkg::req_t     in_word,
	input  logic [7:0]         device_address,
	input  logic [7:0]         timeout_ticks,
	input  logic               buf_full,
	output logic               push,
	output mrtu_pkg::rsp_t     push_word
);
	import mrtu_pkg::*;

	// Input stage
	logic              valid_s1;
	req_t              req_s1;
	logic              fire;

	// Framing state
	mode_t             mode_q, mode_d;
	logic [BCNT_W-1:0] byte_count_q, byte_count_d;
	logic [15:0]       crc_q, crc_d;
	logic [7:0]        first_byte_q, first_byte_d;
	logic [7:0]        silence_q, silence_d;
	logic [15:0]       evt_q [NUM_CNT];
	logic [15:0]       evt_d [NUM_CNT];
	logic              has_res;
	rsp_t              res;
	logic [7:0]        sil_inc;
	logic [BCNT_W-1:0] plen_full;

	// Stage advances unless it would push into a full buffer
	assign fire     = valid_s1 && !(has_res && buf_full);
	assign in_ready = !valid_s1 || fire;
	assign push     = fire && has_res;
	assign push_word = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= in_word;
		end
	end

	// Next state and result for the word in the input stage
	always_comb begin
		mode_d       = mode_q;
		byte_count_d = byte_count_q;
		crc_d        = crc_q;
		first_byte_d = first_byte_q;
		silence_d    = silence_q;
		for (int i = 0; i < NUM_CNT; i++) begin
			evt_d[i] = evt_q[i];
		end
		has_res   = 1'b0;
		res       = '0;
		sil_inc   = (silence_q == 8'hFF) ? silence_q : silence_q + 8'd1;
		plen_full = byte_count_q - BCNT_W'(3);

		unique case (req_s1.req_type)
			REQ_BYTE: begin
				if (mode_q != MODE_RESPONDING) begin
					if (req_s1.overrun_flag || req_s1.parity_flag || req_s1.framing_flag) begin
						if (req_s1.overrun_flag) evt_d[CNT_OVERRUN] = sat_inc16(evt_q[CNT_OVERRUN]);
						if (req_s1.parity_flag)  evt_d[CNT_PARITY]  = sat_inc16(evt_q[CNT_PARITY]);
						if (req_s1.framing_flag) evt_d[CNT_FRAMING] = sat_inc16(evt_q[CNT_FRAMING]);
						byte_count_d = '0;
						crc_d        = CRC_INIT;
						first_byte_d = '0;
						silence_d    = '0;
						mode_d       = MODE_IDLE;
					end else if (byte_count_q >= BCNT_W'(MAX_FRAME_BYTES)) begin
						evt_d[CNT_OVERFLOW] = sat_inc16(evt_q[CNT_OVERFLOW]);
						byte_count_d = '0;
						crc_d        = CRC_INIT;
						first_byte_d = '0;
						silence_d    = '0;
						mode_d       = MODE_IDLE;
					end else begin
						if (byte_count_q == '0) first_byte_d = req_s1.rx_byte;
						crc_d        = crc16_byte(crc_q, req_s1.rx_byte);
						byte_count_d = byte_count_q + BCNT_W'(1);
						silence_d    = '0;
						mode_d       = MODE_RECEIVING;
					end
				end
			end
			REQ_TICK: begin
				if (mode_q == MODE_RECEIVING) begin
					silence_d = sil_inc;
					// Silence gap reached: judge the frame
					if (sil_inc >= timeout_ticks) begin
						has_res = 1'b1;
						evt_d[CNT_SEEN] = evt_q[CNT_SEEN] + 16'd1;
						res.verdict       = VERDICT_SHORT;
						res.frame_address = first_byte_q;
						if (byte_count_q == '0) begin
							res.verdict = VERDICT_SHORT;
						end else if (byte_count_q < BCNT_W'(MIN_FRAME_BYTES)) begin
							evt_d[CNT_SHORT] = sat_inc16(evt_q[CNT_SHORT]);
							res.verdict = VERDICT_SHORT;
						end else begin
							res.pdu_length = plen_full[7:0];
							if (crc_q != 16'h0000) begin
								evt_d[CNT_CRC] = sat_inc16(evt_q[CNT_CRC]);
								res.verdict = VERDICT_CRC_ERR;
							end else if (first_byte_q == ADDR_BCAST) begin
								res.verdict = VERDICT_BCAST;
							end else if (first_byte_q == device_address) begin
								evt_d[CNT_FOR_ME] = evt_q[CNT_FOR_ME] + 16'd1;
								res.verdict = VERDICT_FOR_ME;
							end else begin
								res.verdict = VERDICT_OTHER;
							end
						end
						// A frame for us holds reception until the reply is sent
						if (res.verdict == VERDICT_FOR_ME) begin
							mode_d    = MODE_RESPONDING;
							silence_d = '0;
						end else begin
							mode_d       = MODE_IDLE;
							byte_count_d = '0;
							crc_d        = CRC_INIT;
							first_byte_d = '0;
							silence_d    = '0;
						end
					end
				end
			end
			REQ_TX_DONE: begin
				if (mode_q == MODE_RESPONDING) begin
					mode_d       = MODE_IDLE;
					byte_count_d = '0;
					crc_d        = CRC_INIT;
					first_byte_d = '0;
					silence_d    = '0;
				end
			end
			default: begin
			end
		endcase

		res.frames_seen      = evt_d[CNT_SEEN];
		res.frames_for_me    = evt_d[CNT_FOR_ME];
		res.short_frames     = evt_d[CNT_SHORT];
		res.crc_errors       = evt_d[CNT_CRC];
		res.buffer_overflows = evt_d[CNT_OVERFLOW];
		res.overrun_errors   = evt_d[CNT_OVERRUN];
		res.parity_errors    = evt_d[CNT_PARITY];
		res.framing_errors   = evt_d[CNT_FRAMING];
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			byte_count_q <= '0;
			crc_q        <= CRC_INIT;
			first_byte_q <= '0;
			silence_q    <= '0;
			for (int i = 0; i < NUM_CNT; i++) begin
				evt_q[i] <= '0;
			end
		end else if (fire) begin
			mode_q       <= mode_d;
			byte_count_q <= byte_count_d;
			crc_q        <= crc_d;
			first_byte_q <= first_byte_d;
			silence_q    <= silence_d;
			for (int i = 0; i < NUM_CNT; i++) begin
				evt_q[i] <= evt_d[i];
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= BCNT_W'(MAX_FRAME_BYTES))
		else $error("byte count beyond frame limit");

	a_for_me_holds: assert property (@(posedge clk) disable iff (!arst_n)
		push && (res.verdict == VERDICT_FOR_ME) |=> mode_q == MODE_RESPONDING)
		else $error("frame for this device did not enter responding mode");

	a_resp_len: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_RESPONDING |-> byte_count_q >= BCNT_W'(MIN_FRAME_BYTES))
		else $error("responding with a short frame held");
`endif

endmodule

// ===== rtl/core/mrtu_out_buf.sv =====
// Two-entry result buffer: output register plus skid slot.
// Depends on mrtu_pkg for the result word type.
`timescale 1ns / 1ps

module mrtu_out_buf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mrtu_pkg::rsp_t push_word,
	output logic           full,
	output logic           out_valid,
	input  logic           out_ready,
	output mrtu_pkg::rsp_t out_word
);
	import mrtu_pkg::*;

	logic [1:0] count_q;
	rsp_t       head_q;
	rsp_t       skid_q;
	logic       pop;

	assign pop       = out_valid && out_ready;
	assign full      = (count_q == 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_word  = head_q;

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Data slots: head is always the oldest word
	always_ff @(posedge clk) begin
		priority if (count_q == 2'd0) begin
			if (push) head_q <= push_word;
		end else if (count_q == 2'd1) begin
			if (pop && push) head_q <= push_word;
			else if (push)   skid_q <= push_word;
		end else begin
			if (pop) head_q <= skid_q;
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("result pushed into full buffer");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result buffer occupancy out of range");

	a_head_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("result word changed while waiting");
`endif

endmodule

// ===== rtl/core/modbus_rtu_slave_frame_receiver_unit.sv =====
// Top level of the Modbus RTU slave receive framer.
// Depends on mrtu_pkg, mrtu_if, mrtu_frame_ctrl and mrtu_out_buf.
`timescale 1ns / 1ps

// Usage
//   req: one word per UART event - a received byte with its overrun, parity and
//        framing flags, a silence timer tick, or the end of a reply transmission.
//   rsp: one word each time a silence of timeout_ticks ticks ends a frame: the
//        verdict, address byte, PDU length and all eight event counters.
//   cfg: write port for device_address (index 0) and timeout_ticks (index 1);
//        write only while no word is in flight.
// Timing
//   A request word is accepted into an input register and processed from
//   there; a result is pushed into the output buffer and presented on rsp from it.
//   One word per cycle is accepted in steady state while req.ready stays high;
//   the byte-wide CRC update and frame judgement both finish in the single input stage.
// Reset
//   arst_n clears the mode to idle, empties the frame, sets CRC to 0xFFFF,
//   zeroes all counters and loads address 10 and timeout 3.
// Backpressure
//   Results wait in a two-entry buffer; only when it is full and the staged
//   word would produce a result does req.ready drop.

module modbus_rtu_slave_frame_receiver_unit (
	input  logic       clk,
	input  logic       arst_n,
	mrtu_req_if.sink   req,
	mrtu_rsp_if.source rsp,
	input  logic       cfg_wr_en,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);
	import mrtu_pkg::*;

	logic [7:0] dev_addr_q;
	logic [7:0] timeout_q;
	req_t       in_word;
	rsp_t       push_word;
	rsp_t       out_word;
	logic       push;
	logic       buf_full;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= DEV_ADDR_RST;
			timeout_q  <= TIMEOUT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_DEV_ADDR: dev_addr_q <= cfg_data;
				CFG_TIMEOUT:  timeout_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign in_word.req_type     = req.req_type;
	assign in_word.rx_byte      = req.rx_byte;
	assign in_word.overrun_flag = req.overrun_flag;
	assign in_word.parity_flag  = req.parity_flag;
	assign in_word.framing_flag = req.framing_flag;

	mrtu_frame_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (req.valid),
		.in_ready       (req.ready),
		.in_word        (in_word),
		.device_address (dev_addr_q),
		.timeout_ticks  (timeout_q),
		.buf_full       (buf_full),
		.push           (push),
		.push_word      (push_word)
	);

	mrtu_out_buf u_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.full      (buf_full),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_word  (out_word)
	);

	assign rsp.verdict          = out_word.verdict;
	assign rsp.frame_address    = out_word.frame_address;
	assign rsp.pdu_length       = out_word.pdu_length;
	assign rsp.frames_seen      = out_word.frames_seen;
	assign rsp.frames_for_me    = out_word.frames_for_me;
	assign rsp.short_frames     = out_word.short_frames;
	assign rsp.crc_errors       = out_word.crc_errors;
	assign rsp.buffer_overflows = out_word.buffer_overflows;
	assign rsp.overrun_errors   = out_word.overrun_errors;
	assign rsp.parity_errors    = out_word.parity_errors;
	assign rsp.framing_errors   = out_word.framing_errors;

endmodule
